>>> src/hashed_set_assoc_lookup_cache_unit_defines.svh
// Assertion macros used by the lookup cache top level.
`ifndef HASHED_SET_ASSOC_LOOKUP_CACHE_UNIT_DEFINES_SVH
`define HASHED_SET_ASSOC_LOOKUP_CACHE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define HSLC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hslc: assertion failed");
// Checked at every edge, reset included.
`define HSLC_ASSERT_RST(label, prop) \
    label: assert property (@(posedge clk) prop) \
    else $error("hslc: assertion failed");
`else
`define HSLC_ASSERT(label, prop)
`define HSLC_ASSERT_RST(label, prop)
`endif
`endif

>>> src/hslc_pkg.sv
// Shared types, constants and helper functions of the lookup cache.
`timescale 1ns / 1ps
package hslc_pkg;

    localparam int ENTRIES_DEF = 256;
    localparam int WAYS_DEF    = 8;

    localparam int OP_W    = 3;
    localparam int ID_W    = 32;
    localparam int ST_W    = 4;
    localparam int DADDR_W = 32;

    // Stored states that a query with state zero also matches: 3, 4, 6, 10, 11 and 13.
    localparam logic [15:0] WILDCARD_STATES = 16'h2C58;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP     = 3'd0,
        OP_ADD        = 3'd1,
        OP_CHANGE     = 3'd2,
        OP_FORGET     = 3'd3,
        OP_FORGET_ALL = 3'd4
    } op_t;

    typedef struct packed {
        logic [ID_W-1:0]    key;
        logic [DADDR_W-1:0] daddr;
        logic [ST_W-1:0]    state;
    } entry_t;

    typedef struct packed {
        op_t                op;
        logic [ID_W-1:0]    id;
        logic [ST_W-1:0]    state;
        logic [DADDR_W-1:0] daddr;
    } req_t;

    typedef struct packed {
        logic               found;
        logic [DADDR_W-1:0] address;
    } resp_t;

    typedef struct packed {
        logic row_we;
        logic victim_adv;
    } upd_t;

    // Fold the upper bytes of the id onto the low ones.
    function automatic logic [ID_W-1:0] hash_id(input logic [ID_W-1:0] id);
        return id ^ (id >> 8) ^ (id >> 16) ^ (id >> 24);
    endfunction

    // Key must be equal; state must be equal or be a wildcard hit.
    function automatic logic entry_match(input entry_t e, input logic [ID_W-1:0] id,
                                         input logic [ST_W-1:0] st);
        logic wild;
        wild = (st == '0) && WILDCARD_STATES[e.state];
        return (e.key == id) && ((e.state == st) || wild);
    endfunction

endpackage

>>> src/hslc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module hslc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/hslc_way_match.sv
// Parallel way compare and row update for one set of the lookup cache.
`timescale 1ns / 1ps
module hslc_way_match #(
    parameter int WAYS     = hslc_pkg::WAYS_DEF,
    parameter int WAY_BITS = $clog2(WAYS)
) (
    input  hslc_pkg::entry_t [WAYS-1:0]     row_in,
    input  hslc_pkg::req_t                  req,
    input  logic [WAY_BITS-1:0]             victim,
    input  logic [hslc_pkg::DADDR_W-1:0]    miss_address,
    output hslc_pkg::entry_t [WAYS-1:0]     row_out,
    output hslc_pkg::upd_t                  upd,
    output hslc_pkg::resp_t                 resp
);
    import hslc_pkg::*;

    entry_t [WAYS-1:0]   row_f;
    logic   [WAYS-1:0]   match_raw;
    logic   [WAYS-1:0]   match_f;
    logic   [WAY_BITS-1:0] sel_raw;
    logic   [WAY_BITS-1:0] sel_f;
    logic                forget_en;

    assign forget_en = (req.op == OP_CHANGE) || (req.op == OP_FORGET);

    // Forget pass, on change and forget only: every way holding the id loses key and address.
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            row_f[w] = row_in[w];
            if (forget_en && (row_in[w].key == req.id))
            begin
                row_f[w].key   = '0;
                row_f[w].daddr = '0;
            end
            match_raw[w] = entry_match(row_in[w], req.id, req.state);
            match_f[w]   = entry_match(row_f[w], req.id, req.state);
        end
    end

    // The lowest matching way wins.
    always_comb
    begin
        sel_raw = '0;
        sel_f   = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match_raw[w])
            begin
                sel_raw = WAY_BITS'(w);
            end
            if (match_f[w])
            begin
                sel_f = WAY_BITS'(w);
            end
        end
    end

    // Per-operation row update and response.
    always_comb
    begin
        row_out      = row_f;
        upd          = '0;
        resp         = '0;
        case (req.op)
            OP_LOOKUP:
            begin
                resp.found   = |match_raw;
                resp.address = (|match_raw) ? row_in[sel_raw].daddr : miss_address;
            end
            OP_ADD, OP_CHANGE:
            begin
                upd.row_we = 1'b1;
                if (|match_f)
                begin
                    row_out[sel_f].daddr = req.daddr;
                end
                else
                begin
                    row_out[victim].key   = req.id;
                    row_out[victim].daddr = req.daddr;
                    row_out[victim].state = req.state;
                    upd.victim_adv        = 1'b1;
                end
            end
            OP_FORGET:
            begin
                upd.row_we = 1'b1;
            end
            default:
            begin
                // Forget-all is done by the clearing sweep; unused codes do nothing.
                upd.row_we = 1'b0;
            end
        endcase
    end

endmodule

>>> src/hashed_set_assoc_lookup_cache_unit.sv
// Top level of the hashed set-associative lookup cache.
//
//  Channel   Handshake            Payload
//  -------   ------------------   -----------------------------------------
//  request   req_valid/req_stall  op, object_id, state_code, dir_address
//  response  rsp_valid/rsp_stall  found, result_address
//  config    cfg_wr_en            cfg_wr_data (miss address)
//
// In each transaction the accept cycle reads the set row from the row RAM, and the
// execute state then compares all ways and writes the row back.
// A stalled response holds the read-modify-write cycle until the output register frees.
// After reset, and after each forget-all, a sweep zeroes the row RAM one set per
// cycle, ENTRIES/WAYS sets (32 at the default size), with req_stall high.
// The miss address register resets to all ones; the victim pointer to zero.
`timescale 1ns / 1ps
`include "hashed_set_assoc_lookup_cache_unit_defines.svh"
module hashed_set_assoc_lookup_cache_unit #(
    parameter int ENTRIES = hslc_pkg::ENTRIES_DEF,
    parameter int WAYS    = hslc_pkg::WAYS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [hslc_pkg::OP_W-1:0]     op,
    input  logic [hslc_pkg::ID_W-1:0]     object_id,
    input  logic [hslc_pkg::ST_W-1:0]     state_code,
    input  logic [hslc_pkg::DADDR_W-1:0]  dir_address,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic                          found,
    output logic [hslc_pkg::DADDR_W-1:0]  result_address,
    input  logic                          cfg_wr_en,
    input  logic [hslc_pkg::DADDR_W-1:0]  cfg_wr_data
);
    import hslc_pkg::*;

    localparam int WAY_BITS = $clog2(WAYS);
    localparam int SETS     = ENTRIES / WAYS;
    localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int ROW_W    = WAYS * $bits(entry_t);
    localparam logic [SET_W-1:0] CNT_LAST = SET_W'(SETS - 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_CLEAR = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [SET_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [WAY_BITS-1:0]  victim_reg;
    logic [DADDR_W-1:0]   miss_addr_reg;
    logic                 rsp_valid_reg;
    logic                 found_reg;
    logic [DADDR_W-1:0]   result_reg;
    req_t                 req_reg;
    logic [SET_W-1:0]     set_reg;

    logic                 req_accept;
    logic                 out_free;
    logic                 out_load;
    logic [ID_W-1:0]      hash_w;
    logic [ID_W-1:0]      set_w32;
    logic [SET_W-1:0]     rd_set;
    logic                 ram_we;
    logic [SET_W-1:0]     ram_waddr;
    logic [ROW_W-1:0]     ram_wdata;
    logic [ROW_W-1:0]     ram_rdata;
    entry_t [WAYS-1:0]    rd_row;
    entry_t [WAYS-1:0]    new_row;
    upd_t                 upd;
    resp_t                resp;

    // Handshakes.
    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign out_load   = (state_reg == ST_EXEC) && out_free;

    // Set index of the incoming id.
    assign hash_w  = hash_id(object_id);
    assign set_w32 = (hash_w >> WAY_BITS) & ID_W'(SETS - 1);
    assign rd_set  = set_w32[SET_W-1:0];

    // Row RAM: written back in the execute cycle, or zeroed by the sweep.
    assign ram_we    = (state_reg == ST_CLEAR) || (out_load && upd.row_we);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : set_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : new_row;
    assign rd_row    = ram_rdata;

    hslc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS),
        .AW    (SET_W)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (req_accept),
        .raddr (rd_set),
        .rdata (ram_rdata)
    );

    hslc_way_match #(
        .WAYS     (WAYS),
        .WAY_BITS (WAY_BITS)
    ) u_way_match (
        .row_in       (rd_row),
        .req          (req_reg),
        .victim       (victim_reg),
        .miss_address (miss_addr_reg),
        .row_out      (new_row),
        .upd          (upd),
        .resp         (resp)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = (req_reg.op == OP_FORGET_ALL) ? ST_CLEAR : ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                if (clr_cnt_reg == CNT_LAST)
                begin
                    state_next   = ST_IDLE;
                    clr_cnt_next = '0;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next   = ST_IDLE;
                clr_cnt_next = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            victim_reg    <= '0;
            miss_addr_reg <= '1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (cfg_wr_en)
            begin
                miss_addr_reg <= cfg_wr_data;
            end
            if (out_load && upd.victim_adv)
            begin
                victim_reg <= victim_reg + 1'b1;
            end
            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: request capture and response output.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            req_reg.op    <= op_t'(op);
            req_reg.id    <= object_id;
            req_reg.state <= state_code;
            req_reg.daddr <= dir_address;
            set_reg       <= rd_set;
        end
        if (out_load)
        begin
            found_reg  <= resp.found;
            result_reg <= resp.address;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign found          = found_reg;
    assign result_address = result_reg;

    // Checks on the sequencer and the row RAM write path.
    `HSLC_ASSERT_RST(a_we_state, ram_we |-> (state_reg == ST_EXEC || state_reg == ST_CLEAR))
    `HSLC_ASSERT_RST(a_cnt_rest, (state_reg != ST_CLEAR) |-> (clr_cnt_reg == '0))
    `HSLC_ASSERT(a_accept_exec, req_accept |=> (state_reg == ST_EXEC))
    `HSLC_ASSERT(a_victim_exec, (victim_reg != $past(victim_reg)) |-> $past(state_reg == ST_EXEC))

endmodule
